[rtl/spdf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdf_pkg: shared types and constants
// Request and status codes, field widths and the ID digit check used by the
// strict-priority dual queue; its checker uses the status codes.
// ----------------------------------------------------------------------------
package spdf_pkg;

  localparam int REQ_W     = 3;
  localparam int STAT_W    = 3;
  localparam int NAME_W    = 16;
  localparam int ID_HI_W   = 48;
  localparam int ID_LO_W   = 40;
  localparam int POS_W     = 6;
  localparam int ENTRY_W   = NAME_W + ID_HI_W + ID_LO_W;

  localparam int ID_CHARS   = 11;
  localparam int HIGH_CHARS = 6;
  localparam int LOW_CHARS  = ID_CHARS - HIGH_CHARS;

  localparam logic [7:0] DIGIT_LO = 8'd48;
  localparam logic [7:0] DIGIT_HI = 8'd57;

  localparam logic [REQ_W-1:0] REQ_ENQ   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SERVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_LIST  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_COUNT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DRAIN = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_ID    = 3'd3;
  localparam logic [STAT_W-1:0] ST_HIST_FULL = 3'd4;

  // every byte of the ID must be an ASCII digit
  function automatic logic id_ok(input logic [ID_HI_W-1:0] hi,
                                 input logic [ID_LO_W-1:0] lo);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < HIGH_CHARS; i++) begin
      if (hi[8*i +: 8] < DIGIT_LO || hi[8*i +: 8] > DIGIT_HI) ok = 1'b0;
    end
    for (int i = 0; i < LOW_CHARS; i++) begin
      if (lo[8*i +: 8] < DIGIT_LO || lo[8*i +: 8] > DIGIT_HI) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

[rtl/spdf_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdf_mem: entry store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spdf_mem #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

[rtl/spdf_slot.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdf_slot: circular slot adder
// Shared unit giving (base + offset) wrapped at the queue depth; serves the
// tail slot, list walk slots and head advance.
// ----------------------------------------------------------------------------
module spdf_slot #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic [AW-1:0] base,
  input  logic [AW-1:0] offset,
  output logic [AW-1:0] slot
);

  logic [AW:0] sum;
  logic [AW:0] wrapped;

  always_comb begin
    sum     = {1'b0, base} + {1'b0, offset};
    wrapped = sum - (AW+1)'(DEPTH);
    slot    = (sum >= (AW+1)'(DEPTH)) ? wrapped[AW-1:0] : sum[AW-1:0];
  end

endmodule

[rtl/strict_priority_dual_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_dual_fifo: two-class waiting queue with history
// Priority and normal FIFOs served strictly by class, plus a history log.
// ----------------------------------------------------------------------------
// One request at a time: in_ready is high only while idle. Each request is
// taken in S_IDLE and run in S_EXEC; enqueue and count results are then held
// in S_HOLD, and unknown requests give no result and go back to idle. A serve,
// list or drain with work to do passes through S_FETCH, the registered read of
// the entry stores, and S_CAPTURE, which uses the shared slot adder, before each
// result is held in S_HOLD; out_ready can hold any result off there.
// Entry stores need no clearing after reset; fill counts guard every read.
module strict_priority_dual_fifo #(
  parameter int QUEUE_DEPTH = 16,
  parameter int HIST_DEPTH  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [spdf_pkg::REQ_W-1:0]     in_req_type,
  input  logic                           in_priority_class,
  input  logic [spdf_pkg::ID_HI_W-1:0]   in_id_chars_high,
  input  logic [spdf_pkg::ID_LO_W-1:0]   in_id_chars_low,
  input  logic [spdf_pkg::NAME_W-1:0]    in_name_handle,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [spdf_pkg::STAT_W-1:0]    out_status,
  output logic                           out_served_class,
  output logic [spdf_pkg::NAME_W-1:0]    out_name_handle,
  output logic [spdf_pkg::ID_HI_W-1:0]   out_id_high,
  output logic [spdf_pkg::ID_LO_W-1:0]   out_id_low,
  output logic [spdf_pkg::POS_W-1:0]     out_position,
  output logic [spdf_pkg::POS_W-1:0]     out_waiting_count,
  output logic                           out_last_result
);

  import spdf_pkg::*;

  localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFW = $clog2(QUEUE_DEPTH + 1);
  localparam int HIW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int HFW = $clog2(HIST_DEPTH + 1);
  localparam int KW  = $clog2(2*QUEUE_DEPTH + HIST_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_FETCH, S_CAPTURE, S_HOLD} state_t;

  state_t              state_r, state_nxt;
  logic [REQ_W-1:0]    req_r, req_nxt;
  logic                cls_r, cls_nxt;
  logic [ID_HI_W-1:0]  idh_r, idh_nxt;
  logic [ID_LO_W-1:0]  idl_r, idl_nxt;
  logic [NAME_W-1:0]   name_r, name_nxt;

  logic [QIW-1:0]      prio_head_r, prio_head_nxt;
  logic [QFW-1:0]      prio_fill_r, prio_fill_nxt;
  logic [QIW-1:0]      norm_head_r, norm_head_nxt;
  logic [QFW-1:0]      norm_fill_r, norm_fill_nxt;
  logic [HFW-1:0]      hist_fill_r, hist_fill_nxt;

  logic                walk_cls_r, walk_cls_nxt;
  logic [QFW-1:0]      walk_idx_r, walk_idx_nxt;
  logic [KW-1:0]       walk_k_r, walk_k_nxt;

  logic [STAT_W-1:0]   o_stat_r, o_stat_nxt;
  logic                o_cls_r, o_cls_nxt;
  logic [NAME_W-1:0]   o_name_r, o_name_nxt;
  logic [ID_HI_W-1:0]  o_idh_r, o_idh_nxt;
  logic [ID_LO_W-1:0]  o_idl_r, o_idl_nxt;
  logic [POS_W-1:0]    o_pos_r, o_pos_nxt;
  logic                o_last_r, o_last_nxt;

  logic [QIW-1:0]      slot_base, slot_off, slot;
  logic [KW-1:0]       total;
  logic [KW-1:0]       k_inc;
  logic [QFW-1:0]      tail_fill;
  logic                enq_ok;

  logic                prio_we, norm_we, hist_we, rd_en;
  logic [ENTRY_W-1:0]  wr_entry, prio_rdata, norm_rdata, sel_rdata;
  logic [NAME_W-1:0]   hist_rdata;
  logic [HIW-1:0]      hist_waddr, hist_raddr;

  spdf_slot #(.DEPTH(QUEUE_DEPTH)) u_slot (
    .base   (slot_base),
    .offset (slot_off),
    .slot   (slot)
  );

  spdf_mem #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_prio_mem (
    .clk     (clk),
    .wr_en   (prio_we),
    .wr_addr (slot),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (slot),
    .rd_data (prio_rdata)
  );

  spdf_mem #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_norm_mem (
    .clk     (clk),
    .wr_en   (norm_we),
    .wr_addr (slot),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (slot),
    .rd_data (norm_rdata)
  );

  spdf_mem #(.WIDTH(NAME_W), .DEPTH(HIST_DEPTH)) u_hist_mem (
    .clk     (clk),
    .wr_en   (hist_we),
    .wr_addr (hist_waddr),
    .wr_data (name_r),
    .rd_en   (rd_en),
    .rd_addr (hist_raddr),
    .rd_data (hist_rdata)
  );

  assign total     = KW'(prio_fill_r) + KW'(norm_fill_r);
  assign k_inc     = walk_k_r + KW'(1);
  assign tail_fill = cls_r ? prio_fill_r : norm_fill_r;
  assign enq_ok    = (state_r == S_EXEC) && (req_r == REQ_ENQ) && id_ok(idh_r, idl_r) &&
                     (tail_fill != QFW'(QUEUE_DEPTH));
  assign wr_entry  = {name_r, idh_r, idl_r};
  assign prio_we   = enq_ok && cls_r;
  assign norm_we   = enq_ok && !cls_r;
  assign hist_we   = enq_ok && (hist_fill_r < HFW'(HIST_DEPTH));
  assign hist_waddr = HIW'(hist_fill_r);
  assign hist_raddr = HIW'(walk_k_r);
  assign rd_en     = (state_r == S_FETCH);
  assign sel_rdata = walk_cls_r ? prio_rdata : norm_rdata;

  // shared slot adder: tail on enqueue, walk slot on fetch, head + 1 on serve
  always_comb begin
    case (state_r)
      S_EXEC: begin
        slot_base = cls_r ? prio_head_r : norm_head_r;
        slot_off  = QIW'(tail_fill);
      end
      S_CAPTURE: begin
        slot_base = walk_cls_r ? prio_head_r : norm_head_r;
        slot_off  = QIW'(1);
      end
      default: begin
        slot_base = walk_cls_r ? prio_head_r : norm_head_r;
        slot_off  = QIW'(walk_idx_r);
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cls_nxt       = cls_r;
    idh_nxt       = idh_r;
    idl_nxt       = idl_r;
    name_nxt      = name_r;
    prio_head_nxt = prio_head_r;
    prio_fill_nxt = prio_fill_r;
    norm_head_nxt = norm_head_r;
    norm_fill_nxt = norm_fill_r;
    hist_fill_nxt = hist_fill_r;
    walk_cls_nxt  = walk_cls_r;
    walk_idx_nxt  = walk_idx_r;
    walk_k_nxt    = walk_k_r;
    o_stat_nxt    = o_stat_r;
    o_cls_nxt     = o_cls_r;
    o_name_nxt    = o_name_r;
    o_idh_nxt     = o_idh_r;
    o_idl_nxt     = o_idl_r;
    o_pos_nxt     = o_pos_r;
    o_last_nxt    = o_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_type;
          cls_nxt   = in_priority_class;
          idh_nxt   = in_id_chars_high;
          idl_nxt   = in_id_chars_low;
          name_nxt  = in_name_handle;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        o_stat_nxt = ST_OK;
        o_cls_nxt  = 1'b0;
        o_name_nxt = '0;
        o_idh_nxt  = '0;
        o_idl_nxt  = '0;
        o_pos_nxt  = '0;
        o_last_nxt = 1'b1;
        walk_idx_nxt = '0;
        walk_k_nxt   = '0;
        state_nxt    = S_HOLD;
        case (req_r)
          REQ_ENQ: begin
            o_cls_nxt = cls_r;
            if (!id_ok(idh_r, idl_r)) begin
              o_stat_nxt = ST_BAD_ID;
            end else if (tail_fill == QFW'(QUEUE_DEPTH)) begin
              o_stat_nxt = ST_FULL;
            end else begin
              if (cls_r) prio_fill_nxt = prio_fill_r + QFW'(1);
              else       norm_fill_nxt = norm_fill_r + QFW'(1);
              if (hist_we) hist_fill_nxt = hist_fill_r + HFW'(1);
              else         o_stat_nxt    = ST_HIST_FULL;
            end
          end
          REQ_SERVE, REQ_LIST: begin
            if (total == '0) begin
              o_stat_nxt = ST_EMPTY;
            end else begin
              walk_cls_nxt = (prio_fill_r != '0);
              state_nxt    = S_FETCH;
            end
          end
          REQ_COUNT: begin
            o_stat_nxt = ST_OK;
          end
          REQ_DRAIN: begin
            if (hist_fill_r == '0) begin
              o_stat_nxt = ST_EMPTY;
            end else begin
              walk_cls_nxt = 1'b0;
              state_nxt    = S_FETCH;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_FETCH: begin
        state_nxt = S_CAPTURE;
      end
      S_CAPTURE: begin
        o_stat_nxt = ST_OK;
        o_pos_nxt  = '0;
        o_last_nxt = 1'b1;
        state_nxt  = S_HOLD;
        case (req_r)
          REQ_DRAIN: begin
            o_cls_nxt  = 1'b0;
            o_name_nxt = hist_rdata;
            o_idh_nxt  = '0;
            o_idl_nxt  = '0;
            o_last_nxt = (k_inc == KW'(hist_fill_r));
          end
          default: begin
            o_cls_nxt = walk_cls_r;
            {o_name_nxt, o_idh_nxt, o_idl_nxt} = sel_rdata;
            if (req_r == REQ_LIST) begin
              o_pos_nxt  = POS_W'(k_inc);
              o_last_nxt = (k_inc == total);
            end else if (walk_cls_r) begin
              prio_head_nxt = slot;
              prio_fill_nxt = prio_fill_r - QFW'(1);
            end else begin
              norm_head_nxt = slot;
              norm_fill_nxt = norm_fill_r - QFW'(1);
            end
          end
        endcase
      end
      S_HOLD: begin
        if (out_ready) begin
          if (o_last_r) begin
            if (req_r == REQ_DRAIN) hist_fill_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            walk_k_nxt = k_inc;
            if (walk_cls_r && (walk_idx_r + QFW'(1) == prio_fill_r)) begin
              walk_cls_nxt = 1'b0;
              walk_idx_nxt = '0;
            end else begin
              walk_idx_nxt = walk_idx_r + QFW'(1);
            end
            state_nxt = S_FETCH;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prio_head_r <= '0;
      prio_fill_r <= '0;
      norm_head_r <= '0;
      norm_fill_r <= '0;
      hist_fill_r <= '0;
      walk_cls_r  <= 1'b0;
      walk_idx_r  <= '0;
      walk_k_r    <= '0;
      req_r       <= REQ_COUNT;
      o_last_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prio_head_r <= prio_head_nxt;
      prio_fill_r <= prio_fill_nxt;
      norm_head_r <= norm_head_nxt;
      norm_fill_r <= norm_fill_nxt;
      hist_fill_r <= hist_fill_nxt;
      walk_cls_r  <= walk_cls_nxt;
      walk_idx_r  <= walk_idx_nxt;
      walk_k_r    <= walk_k_nxt;
      req_r       <= req_nxt;
      o_last_r    <= o_last_nxt;
      cls_r       <= cls_nxt;
      idh_r       <= idh_nxt;
      idl_r       <= idl_nxt;
      name_r      <= name_nxt;
      o_stat_r    <= o_stat_nxt;
      o_cls_r     <= o_cls_nxt;
      o_name_r    <= o_name_nxt;
      o_idh_r     <= o_idh_nxt;
      o_idl_r     <= o_idl_nxt;
      o_pos_r     <= o_pos_nxt;
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = (state_r == S_HOLD);
  assign out_status        = o_stat_r;
  assign out_served_class  = o_cls_r;
  assign out_name_handle   = o_name_r;
  assign out_id_high       = o_idh_r;
  assign out_id_low        = o_idl_r;
  assign out_position      = o_pos_r;
  assign out_waiting_count = POS_W'(total);
  assign out_last_result   = o_last_r;

endmodule

[rtl/spdf_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdf_chk: port checker
// Watches the top-level ports of the dual queue over time.
// ----------------------------------------------------------------------------
module spdf_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [spdf_pkg::STAT_W-1:0]  out_status,
  input logic                         out_served_class,
  input logic [spdf_pkg::NAME_W-1:0]  out_name_handle,
  input logic [spdf_pkg::ID_HI_W-1:0] out_id_high,
  input logic [spdf_pkg::ID_LO_W-1:0] out_id_low,
  input logic [spdf_pkg::POS_W-1:0]   out_position,
  input logic [spdf_pkg::POS_W-1:0]   out_waiting_count,
  input logic                         out_last_result
);

  import spdf_pkg::*;

  // one item in flight: no new item while a result is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_served_class) && $stable(out_name_handle) &&
      $stable(out_id_high) && $stable(out_id_low) && $stable(out_position) &&
      $stable(out_waiting_count) && $stable(out_last_result))
    else $error("stalled result changed");

  // error and empty results always close the request
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK && out_status != ST_HIST_FULL |-> out_last_result)
    else $error("non-final error result");

  // more results follow a non-final one, so no new item is taken
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_result |=> !in_ready)
    else $error("input ready in the middle of a walk");

endmodule

bind strict_priority_dual_fifo spdf_chk u_spdf_chk (.*);
